// ===== sv/lbvs_pkg.sv =====
// Shared constants and types of the linear blend skinning block.
package lbvs_pkg;

	localparam int JOINT_COUNT_DEF = 256;
	localparam int INFLUENCES_DEF  = 4;
	localparam int MAT_WORDS       = 12;
	localparam int ROW_WORDS       = 4;

	localparam int IN_DATA_W  = 288;
	localparam int OUT_DATA_W = 144;
	localparam int POS_TAG_W  = 97;

	localparam int WPROD_W  = 49;
	localparam int ACC_W    = 50;
	localparam int BLEND_W  = 35;
	localparam int HI_W     = 51;
	localparam int LO_W     = 52;
	localparam int RES_W    = 56;
	localparam int NV_W     = 53;

	localparam int GRP_N    = 7;
	localparam int NRM_W    = 30;
	localparam int SQR_W    = 60;
	localparam int SQ_W     = 62;
	localparam int LEN_W    = 31;
	localparam int NUM_W    = 46;
	localparam int QUO_W    = 15;
	localparam int NOUT_W   = 16;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_SKIN  = 1'b1;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} rest_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic use_j;
	} fetch_t;

endpackage

// ===== sv/lbvs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module lbvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== sv/lbvs_norm.sv =====
// Normal normalization pipeline: scale, sum of squares, square root, divide.
module lbvs_norm import lbvs_pkg::*; #(
	parameter int TAG_W = POS_TAG_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [NV_W-1:0]  in_nv [3],
	input  logic [TAG_W-1:0]        in_tag,
	output logic                    out_valid,
	output logic [NOUT_W-1:0]       out_n [3],
	output logic [TAG_W-1:0]        out_tag
);

	function automatic logic [2:0] msb8(input logic [7:0] b);
		logic [2:0] p;
		p = '0;
		for (int i = 0; i < 8; i++)
			if (b[i])
				p = 3'(i);
		return p;
	endfunction

	logic v_a, v_b, v_c, v_d, v_e, v_f, v_g;
	logic [NV_W-1:0] mag_a [3], mag_b [3], mag_c [3], mag_d [3];
	logic [2:0] neg_a, neg_b, neg_c, neg_d, neg_e, neg_f, neg_g;
	logic [TAG_W-1:0] tag_a, tag_b, tag_c, tag_d, tag_e, tag_f, tag_g;
	logic [NV_W-1:0] mx_b;
	logic [GRP_N-1:0] gnz_c;
	logic [2:0] gpos_c [GRP_N];
	logic [5:0] msb_d;
	logic zero_d, zero_e, zero_f, zero_g;
	logic [NRM_W-1:0] mag_e [3], mag_f [3], mag_g [3];
	logic [SQR_W-1:0] sq_f [3];
	logic [SQ_W-1:0] sum_g;

	logic [GRP_N*8-1:0] mx_pad;
	logic [5:0] msb_n;
	logic nz_n;
	logic [5:0] sh;
	logic sh_right;

	assign mx_pad = (GRP_N*8)'(mx_b);

	always_comb begin
		msb_n = '0;
		nz_n = 1'b0;
		for (int g = 0; g < GRP_N; g++) begin
			if (gnz_c[g]) begin
				msb_n = {3'(g), gpos_c[g]};
				nz_n = 1'b1;
			end
		end
	end

	// largest magnitude lands in [2^29, 2^30)
	assign sh_right = (msb_d >= 6'(NRM_W));
	assign sh = sh_right ? (msb_d - 6'(NRM_W-1)) : (6'(NRM_W-1) - msb_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_a, v_b, v_c, v_d, v_e, v_f, v_g} <= '0;
		end else if (en) begin
			{v_a, v_b, v_c, v_d, v_e, v_f, v_g} <= {in_valid, v_a, v_b, v_c, v_d, v_e, v_f};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_a[k] <= in_nv[k][NV_W-1];
				mag_a[k] <= in_nv[k][NV_W-1] ? NV_W'(-in_nv[k]) : NV_W'(in_nv[k]);
			end
			tag_a <= in_tag;

			mx_b <= (mag_a[0] > mag_a[1]) ?
				((mag_a[0] > mag_a[2]) ? mag_a[0] : mag_a[2]) :
				((mag_a[1] > mag_a[2]) ? mag_a[1] : mag_a[2]);
			mag_b <= mag_a;
			neg_b <= neg_a;
			tag_b <= tag_a;

			for (int g = 0; g < GRP_N; g++) begin
				gnz_c[g]  <= |mx_pad[g*8 +: 8];
				gpos_c[g] <= msb8(mx_pad[g*8 +: 8]);
			end
			mag_c <= mag_b;
			neg_c <= neg_b;
			tag_c <= tag_b;

			msb_d  <= msb_n;
			zero_d <= !nz_n;
			mag_d  <= mag_c;
			neg_d  <= neg_c;
			tag_d  <= tag_c;

			for (int k = 0; k < 3; k++)
				mag_e[k] <= sh_right ? NRM_W'(mag_d[k] >> sh) : NRM_W'(mag_d[k] << sh);
			zero_e <= zero_d;
			neg_e  <= neg_d;
			tag_e  <= tag_d;

			for (int k = 0; k < 3; k++)
				sq_f[k] <= mag_e[k] * mag_e[k];
			mag_f  <= mag_e;
			zero_f <= zero_e;
			neg_f  <= neg_e;
			tag_f  <= tag_e;

			sum_g  <= SQ_W'(sq_f[0]) + SQ_W'(sq_f[1]) + SQ_W'(sq_f[2]);
			mag_g  <= mag_f;
			zero_g <= zero_f;
			neg_g  <= neg_f;
			tag_g  <= tag_f;
		end
	end

	// square root: one result bit per stage
	logic [SQ_W-1:0]  srem  [0:LEN_W];
	logic [SQ_W-1:0]  sroot [0:LEN_W];
	logic             sv    [0:LEN_W];
	logic             szero [0:LEN_W];
	logic [2:0]       sneg  [0:LEN_W];
	logic [NRM_W-1:0] smag  [0:LEN_W][3];
	logic [TAG_W-1:0] stag  [0:LEN_W];

	assign srem[0]  = sum_g;
	assign sroot[0] = '0;
	assign sv[0]    = v_g;
	assign szero[0] = zero_g;
	assign sneg[0]  = neg_g;
	assign smag[0]  = mag_g;
	assign stag[0]  = tag_g;

	for (genvar i = 0; i < LEN_W; i++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (LEN_W - 1 - i));
		logic [SQ_W-1:0] trial;
		assign trial = sroot[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sv[i+1] <= 1'b0;
			else if (en)
				sv[i+1] <= sv[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (srem[i] >= trial) begin
					srem[i+1]  <= srem[i] - trial;
					sroot[i+1] <= (sroot[i] >> 1) + BIT;
				end else begin
					srem[i+1]  <= srem[i];
					sroot[i+1] <= sroot[i] >> 1;
				end
				szero[i+1] <= szero[i];
				sneg[i+1]  <= sneg[i];
				smag[i+1]  <= smag[i];
				stag[i+1]  <= stag[i];
			end
		end
	end

	// restoring divide, one quotient bit per stage, three lanes
	logic [NUM_W-1:0] drem  [0:QUO_W][3];
	logic [QUO_W-1:0] dquo  [0:QUO_W][3];
	logic [LEN_W-1:0] dden  [0:QUO_W];
	logic             dv    [0:QUO_W];
	logic             dzero [0:QUO_W];
	logic [2:0]       dneg  [0:QUO_W];
	logic [TAG_W-1:0] dtag  [0:QUO_W];
	logic [LEN_W-1:0] len;

	assign len = sroot[LEN_W][LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv[0] <= 1'b0;
		else if (en)
			dv[0] <= sv[LEN_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				drem[0][k] <= (NUM_W'(smag[LEN_W][k]) << (NOUT_W - 2)) + NUM_W'(len >> 1);
				dquo[0][k] <= '0;
			end
			dden[0]  <= szero[LEN_W] ? LEN_W'(1) : len;
			dzero[0] <= szero[LEN_W];
			dneg[0]  <= sneg[LEN_W];
			dtag[0]  <= stag[LEN_W];
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		localparam int B = QUO_W - 1 - i;
		logic [NUM_W-1:0] dtrial;
		assign dtrial = NUM_W'(dden[i]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv[i+1] <= 1'b0;
			else if (en)
				dv[i+1] <= dv[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					if (drem[i][k] >= dtrial) begin
						drem[i+1][k] <= drem[i][k] - dtrial;
						dquo[i+1][k] <= dquo[i][k] | (QUO_W'(1) << B);
					end else begin
						drem[i+1][k] <= drem[i][k];
						dquo[i+1][k] <= dquo[i][k];
					end
				end
				dden[i+1]  <= dden[i];
				dzero[i+1] <= dzero[i];
				dneg[i+1]  <= dneg[i];
				dtag[i+1]  <= dtag[i];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (dzero[QUO_W])
				out_n[k] = '0;
			else if (dneg[QUO_W][k])
				out_n[k] = -{1'b0, dquo[QUO_W][k]};
			else
				out_n[k] = {1'b0, dquo[QUO_W][k]};
		end
	end

	assign out_valid = dv[QUO_W];
	assign out_tag   = dtag[QUO_W];

endmodule

// ===== sv/linear_blend_vertex_skinning_top.sv =====
// Linear blend skinning unit: joint matrix store, blend, transform, normalize.
//
// Input stream (s_*): tuser selects the word kind. A write word stores one
// Q16.16 element of a joint's 3x4 matrix; a skin word carries a rest
// position, rest normal, four joint indices and four Q1.15 weights.
// Output stream (m_*): one word per skin word, skinned position in tdata
// with the unit normal, and the position saturation flag in tuser.
// Write words produce no output.
// Throughput: write words one per cycle unless a vertex is being read or the
// output stalls; the twelve-bank matrix store delivers one whole joint matrix
// per cycle, one influence per cycle, and a new skin word is taken together
// with the last matrix read of the current vertex. Most of the pipeline stages
// lie in the normalization: the square root (one bit per stage) and the
// three-lane divide.
// Reset clears all control and valid state; the matrix store is not cleared
// and a joint must be written before a vertex uses it.
// When the receiver stalls with an output word waiting, the whole pipeline
// and the store read hold until the word is taken.
module linear_blend_vertex_skinning_top import lbvs_pkg::*; #(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF,
	parameter int INFLUENCES  = INFLUENCES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, joint_indices, weights,
	// write_joint, write_element, write_value, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_x, out_y, out_z, out_nx, out_ny, out_nz
	output logic [OUT_DATA_W-1:0] m_tdata,
	// saturated
	output logic [0:0]            m_tuser
);

	localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int KW = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;

	rest_t       in_rest;
	logic [31:0] in_ji;
	logic [63:0] in_w;
	logic [7:0]  in_wj;
	logic [3:0]  in_we;
	logic [31:0] in_wv;

	assign in_rest.x  = s_tdata[31:0];
	assign in_rest.y  = s_tdata[63:32];
	assign in_rest.z  = s_tdata[95:64];
	assign in_rest.nx = s_tdata[111:96];
	assign in_rest.ny = s_tdata[127:112];
	assign in_rest.nz = s_tdata[143:128];
	assign in_ji      = s_tdata[175:144];
	assign in_w       = s_tdata[239:176];
	assign in_wj      = s_tdata[247:240];
	assign in_we      = s_tdata[251:248];
	assign in_wv      = s_tdata[283:252];

	logic en, busy_q, last_rd, take, wr, skin;
	logic [KW-1:0] k_q;

	assign en      = !m_tvalid || m_tready;
	assign last_rd = busy_q && (k_q == KW'(INFLUENCES - 1));
	// next word only once the last matrix of the current vertex is read
	assign s_tready = en && (!busy_q || last_rd);
	assign take     = s_tvalid && s_tready;
	assign skin     = take && (s_tuser[0] == FUNC_SKIN);
	assign wr       = take && (s_tuser[0] == FUNC_WRITE) && (in_we < 4'(MAT_WORDS))
		&& ({1'b0, in_wj} < 9'(JOINT_COUNT));

	rest_t       rest_q;
	logic [31:0] ji_q;
	logic [63:0] w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (en) begin
			if (skin) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (last_rd)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skin) begin
			rest_q <= in_rest;
			ji_q   <= in_ji;
			w_q    <= in_w;
		end
	end

	logic [7:0]  rd_j;
	logic [15:0] rd_w;
	logic        rd_use, rd_en;
	logic [31:0] rd_data [MAT_WORDS];

	assign rd_j   = ji_q[k_q*8 +: 8];
	assign rd_w   = w_q[k_q*16 +: 16];
	assign rd_use = ({1'b0, rd_j} < 9'(JOINT_COUNT));
	assign rd_en  = en && busy_q;

	for (genvar e = 0; e < MAT_WORDS; e++) begin : g_bank
		lbvs_ram #(
			.WIDTH (32),
			.DEPTH (JOINT_COUNT),
			.AW    (JW)
		) u_bank (
			.clk   (clk),
			.we    (wr && (in_we == 4'(e))),
			.waddr (in_wj[JW-1:0]),
			.wdata (in_wv),
			.re    (rd_en),
			.raddr (rd_j[JW-1:0]),
			.rdata (rd_data[e])
		);
	end

	// weighted accumulation over influences
	fetch_t ctl_s1, ctl_s2;
	logic [15:0] w_s1;
	rest_t rest_s1, rest_s2, rest_a_q, rest_s3;
	logic signed [WPROD_W-1:0] prod_s2 [MAT_WORDS];
	logic signed [ACC_W-1:0]   acc_q [MAT_WORDS];
	logic done_q, v_s3, v_s4, v_s5;
	logic signed [BLEND_W-1:0] blend_s3 [MAT_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else if (en) begin
			ctl_s1 <= '{valid: busy_q, first: (k_q == '0), last: last_rd, use_j: rd_use};
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
			v_s3   <= done_q;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= rd_w;
			if (last_rd)
				rest_s1 <= rest_q;
			rest_s2 <= rest_s1;
			for (int e = 0; e < MAT_WORDS; e++) begin
				if (ctl_s1.use_j)
					prod_s2[e] <= $signed({1'b0, w_s1}) * $signed(rd_data[e]);
				else
					prod_s2[e] <= '0;
			end
			if (ctl_s2.valid) begin
				for (int e = 0; e < MAT_WORDS; e++)
					acc_q[e] <= ctl_s2.first ? ACC_W'(prod_s2[e]) :
						acc_q[e] + ACC_W'(prod_s2[e]);
				if (ctl_s2.last)
					rest_a_q <= rest_s2;
			end
			// round half up from Q.31 to Q16.16
			for (int e = 0; e < MAT_WORDS; e++)
				blend_s3[e] <= BLEND_W'((acc_q[e] + ACC_W'(16384)) >>> 15);
			rest_s3 <= rest_a_q;
		end
	end

	// transform: position split into integer and fraction halves
	logic signed [15:0] ph [3];
	logic signed [16:0] pl [3];
	logic signed [15:0] nr [3];

	assign ph[0] = rest_s3.x[31:16];
	assign ph[1] = rest_s3.y[31:16];
	assign ph[2] = rest_s3.z[31:16];
	assign pl[0] = {1'b0, rest_s3.x[15:0]};
	assign pl[1] = {1'b0, rest_s3.y[15:0]};
	assign pl[2] = {1'b0, rest_s3.z[15:0]};
	assign nr[0] = rest_s3.nx;
	assign nr[1] = rest_s3.ny;
	assign nr[2] = rest_s3.nz;

	logic signed [HI_W-1:0]    hi_s4 [3][3];
	logic signed [LO_W-1:0]    lo_s4 [3][3];
	logic signed [HI_W-1:0]    nm_s4 [3][3];
	logic signed [BLEND_W-1:0] t_s4 [3];
	logic signed [RES_W-1:0]   res_s5 [3];
	logic signed [NV_W-1:0]    nv_s5 [3];
	logic signed [HI_W+1:0]    hs [3];
	logic signed [LO_W+1:0]    ls [3];
	logic signed [LO_W+1:0]    lr [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			hs[r] = (HI_W+2)'(hi_s4[r][0]) + (HI_W+2)'(hi_s4[r][1]) + (HI_W+2)'(hi_s4[r][2]);
			ls[r] = (LO_W+2)'(lo_s4[r][0]) + (LO_W+2)'(lo_s4[r][1]) + (LO_W+2)'(lo_s4[r][2]);
			lr[r] = (ls[r] + (LO_W+2)'(32768)) >>> 16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					hi_s4[r][c] <= blend_s3[r*ROW_WORDS+c] * ph[c];
					lo_s4[r][c] <= blend_s3[r*ROW_WORDS+c] * pl[c];
					nm_s4[r][c] <= blend_s3[r*ROW_WORDS+c] * nr[c];
				end
				t_s4[r] <= blend_s3[r*ROW_WORDS+ROW_WORDS-1];
			end
			for (int r = 0; r < 3; r++) begin
				res_s5[r] <= RES_W'(hs[r]) + RES_W'(lr[r]) + RES_W'(t_s4[r]);
				nv_s5[r]  <= NV_W'(nm_s4[r][0]) + NV_W'(nm_s4[r][1]) + NV_W'(nm_s4[r][2]);
			end
		end
	end

	// saturation: fits when all bits above bit 31 match the sign
	logic [31:0] pos_c [3];
	logic [2:0]  clip;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			clip[r] = !((&res_s5[r][RES_W-1:31]) || !(|res_s5[r][RES_W-1:31]));
			if (clip[r])
				pos_c[r] = res_s5[r][RES_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else
				pos_c[r] = res_s5[r][31:0];
		end
	end

	logic                  n_valid;
	logic [NOUT_W-1:0]     n_out [3];
	logic [POS_TAG_W-1:0]  n_tag;

	lbvs_norm #(
		.TAG_W (POS_TAG_W)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_nv     (nv_s5),
		.in_tag    ({|clip, pos_c[2], pos_c[1], pos_c[0]}),
		.out_valid (n_valid),
		.out_n     (n_out),
		.out_tag   (n_tag)
	);

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (en)
			m_valid_q <= n_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= {n_out[2], n_out[1], n_out[0], n_tag[95:0]};
			m_sat_q  <= n_tag[96];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_sat_q;

endmodule
